// ===== rtl/oqu_pkg.sv =====
// shared constants and types for the orientation quaternion unit
// no dependencies; imported by the square-root, divider and top-level files
package oqu_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 24;

  // square root of a double-width word, one result bit per stage
  localparam int SQ_IN_BITS = 2 * WORD_BITS;
  localparam int SQ_STAGES  = WORD_BITS;

  // restoring divider, one quotient bit per stage
  localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
  localparam int DEN_BITS   = WORD_BITS;
  localparam int DV_STAGES  = NUM_BITS;

  // product, sum and rounding widths
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int SUM_BITS   = 2 * WORD_BITS + 4;
  localparam int RND_BITS   = SUM_BITS - FRAC_BITS;
  localparam int MUL_BITS   = FRAC_BITS + 1 + WORD_BITS;
  localparam int SAT_BITS   = (NUM_BITS + 1 > RND_BITS + 1) ? NUM_BITS + 1 : RND_BITS + 1;

  // total register stages from request acceptance to the output register
  localparam int LAT        = 3 + SQ_STAGES + DV_STAGES + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam logic [1:0] CMD_TO_QUAT = 2'd0;
  localparam logic [1:0] CMD_PRODUCT = 2'd1;
  localparam logic [1:0] CMD_TO_ROD  = 2'd2;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_SAT   = 2'd1;
  localparam logic [1:0] FAULT_DIV0  = 2'd2;
  localparam logic [1:0] FAULT_CMD   = 2'd3;

endpackage

// ===== rtl/oqu_sqrt.sv =====
// pipelined integer square root, one result bit resolved per register stage
// depends on oqu_pkg
module oqu_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [oqu_pkg::SQ_IN_BITS-1:0]   n,
  output logic [oqu_pkg::SQ_STAGES-1:0]    root
);
  import oqu_pkg::*;

  logic [SQ_IN_BITS-1:0] rem_r    [SQ_STAGES];
  logic [SQ_IN_BITS-1:0] res_r    [SQ_STAGES];
  logic [SQ_IN_BITS-1:0] rem_next [SQ_STAGES];
  logic [SQ_IN_BITS-1:0] res_next [SQ_STAGES];

  // one digit-pair trial per stage, bit weight falling by a factor of four each stage
  always_comb begin
    logic [SQ_IN_BITS-1:0] r_in;
    logic [SQ_IN_BITS-1:0] q_in;
    logic [SQ_IN_BITS-1:0] bit_w;
    logic [SQ_IN_BITS-1:0] trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      r_in  = (k == 0) ? n : rem_r[(k == 0) ? 0 : k - 1];
      q_in  = (k == 0) ? '0 : res_r[(k == 0) ? 0 : k - 1];
      bit_w = SQ_IN_BITS'(1) << (SQ_IN_BITS - 2 - 2 * k);
      trial = q_in + bit_w;
      if (r_in >= trial) begin
        rem_next[k] = r_in - trial;
        res_next[k] = (q_in >> 1) + bit_w;
      end else begin
        rem_next[k] = r_in;
        res_next[k] = q_in >> 1;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_r[k] <= rem_next[k];
        res_r[k] <= res_next[k];
      end
    end
  end

  assign root = res_r[SQ_STAGES-1][SQ_STAGES-1:0];

endmodule

// ===== rtl/oqu_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per register stage
// depends on oqu_pkg
module oqu_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [oqu_pkg::NUM_BITS-1:0]   num,
  input  logic [oqu_pkg::DEN_BITS-1:0]   den,
  output logic [oqu_pkg::NUM_BITS-1:0]   quo
);
  import oqu_pkg::*;

  logic [DEN_BITS-1:0] rem_r    [DV_STAGES];
  logic [NUM_BITS-1:0] nq_r     [DV_STAGES];
  logic [DEN_BITS-1:0] den_r    [DV_STAGES];
  logic [DEN_BITS-1:0] rem_next [DV_STAGES];
  logic [NUM_BITS-1:0] nq_next  [DV_STAGES];
  logic [DEN_BITS-1:0] den_next [DV_STAGES];

  // shift in one dividend bit, subtract when the divisor fits
  always_comb begin
    logic [DEN_BITS-1:0] r_in;
    logic [NUM_BITS-1:0] n_in;
    logic [DEN_BITS-1:0] d_in;
    logic [DEN_BITS:0]   t;
    logic                qb;
    for (int k = 0; k < DV_STAGES; k++) begin
      r_in = (k == 0) ? '0  : rem_r[(k == 0) ? 0 : k - 1];
      n_in = (k == 0) ? num : nq_r[(k == 0) ? 0 : k - 1];
      d_in = (k == 0) ? den : den_r[(k == 0) ? 0 : k - 1];
      t    = {r_in, n_in[NUM_BITS-1]};
      qb   = (t >= {1'b0, d_in});
      if (qb) begin
        rem_next[k] = DEN_BITS'(t - {1'b0, d_in});
      end else begin
        rem_next[k] = t[DEN_BITS-1:0];
      end
      nq_next[k]  = {n_in[NUM_BITS-2:0], qb};
      den_next[k] = d_in;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DV_STAGES; k++) begin
        rem_r[k] <= rem_next[k];
        nq_r[k]  <= nq_next[k];
        den_r[k] <= den_next[k];
      end
    end
  end

  assign quo = nq_r[DV_STAGES-1];

endmodule

// ===== rtl/orientation_quaternion_unit.sv =====
// orientation quaternion unit: rodrigues to quaternion, quaternion product,
// quaternion to rodrigues, fixed point, depends on oqu_pkg, oqu_sqrt, oqu_div
// pipeline: 3 front stages, 32 square-root stages, 56 divider stages and 2 back
// stages from request acceptance to result valid; throughput one request per cycle
// while results are taken; the whole pipeline holds while a result waits untaken
// reset clears the stage valid bits only, payload registers are not reset
module orientation_quaternion_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up
  input  logic [8*oqu_pkg::WORD_BITS-1:0]   s_tdata,
  // cmd
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // r_w, r_x, r_y, r_z from the lowest bit up
  output logic [4*oqu_pkg::WORD_BITS-1:0]   m_tdata,
  // fault
  output logic [1:0]                        m_tuser
);
  import oqu_pkg::*;

  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic signed [RND_BITS-1:0]  rnd_t;
  typedef logic signed [MUL_BITS-1:0]  mul_t;
  typedef logic signed [SAT_BITS-1:0]  sat_t;

  typedef struct packed {
    logic [1:0]          cmd;
    word_t               ax;
    word_t               ay;
    word_t               az;
    word_t               qw;
    word_t               qx;
    word_t               qy;
    word_t               qz;
    logic                qsat;
    logic [DEN_BITS-1:0] ux;
    logic [DEN_BITS-1:0] uy;
    logic [DEN_BITS-1:0] uz;
    logic [DEN_BITS-1:0] ud;
    logic [2:0]          neg;
    logic                azero;
  } side_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam sum_t  HALF_S = SUM_BITS'(1) << (FRAC_BITS - 1);
  localparam mul_t  HALF_M = MUL_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [NUM_BITS-1:0]   ONE2F = NUM_BITS'(1) << (2 * FRAC_BITS);
  localparam logic [SQ_IN_BITS-1:0] ONE2F_SQ = SQ_IN_BITS'(1) << (2 * FRAC_BITS);

  function automatic logic sat_ovf(input sat_t v);
    logic [SAT_BITS-WORD_BITS:0] hi;
    hi = v[SAT_BITS-1:WORD_BITS-1];
    return !((&hi) || !(|hi));
  endfunction

  function automatic word_t sat_word(input sat_t v);
    if (sat_ovf(v)) begin
      return v[SAT_BITS-1] ? WMIN : WMAX;
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] abs_word(input word_t v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  logic adv;
  logic [LAT-1:0] vld;

  // global advance: the pipeline moves unless the output register is held
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  word_t iw [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      iw[i] = s_tdata[i*WORD_BITS +: WORD_BITS];
    end
  end

  // stage 1: all products and squares
  prod_t      p1 [19];
  word_t      a1 [4];
  logic [1:0] cmd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1[0]  <= prod_t'(iw[0]) * prod_t'(iw[4]);
      p1[1]  <= prod_t'(iw[5]) * prod_t'(iw[1]);
      p1[2]  <= prod_t'(iw[6]) * prod_t'(iw[2]);
      p1[3]  <= prod_t'(iw[7]) * prod_t'(iw[3]);
      p1[4]  <= prod_t'(iw[0]) * prod_t'(iw[5]);
      p1[5]  <= prod_t'(iw[4]) * prod_t'(iw[1]);
      p1[6]  <= prod_t'(iw[2]) * prod_t'(iw[7]);
      p1[7]  <= prod_t'(iw[6]) * prod_t'(iw[3]);
      p1[8]  <= prod_t'(iw[0]) * prod_t'(iw[6]);
      p1[9]  <= prod_t'(iw[4]) * prod_t'(iw[2]);
      p1[10] <= prod_t'(iw[1]) * prod_t'(iw[7]);
      p1[11] <= prod_t'(iw[5]) * prod_t'(iw[3]);
      p1[12] <= prod_t'(iw[0]) * prod_t'(iw[7]);
      p1[13] <= prod_t'(iw[4]) * prod_t'(iw[3]);
      p1[14] <= prod_t'(iw[1]) * prod_t'(iw[6]);
      p1[15] <= prod_t'(iw[5]) * prod_t'(iw[2]);
      p1[16] <= prod_t'(iw[1]) * prod_t'(iw[1]);
      p1[17] <= prod_t'(iw[2]) * prod_t'(iw[2]);
      p1[18] <= prod_t'(iw[3]) * prod_t'(iw[3]);
      for (int i = 0; i < 4; i++) begin
        a1[i] <= iw[i];
      end
      cmd1 <= s_tuser;
    end
  end

  // stage 2: product sums rounded half up, squared norm plus one
  sum_t                  e1 [16];
  sum_t                  sw, sx, sy, sz;
  rnd_t                  r2 [4];
  logic [SQ_IN_BITS-1:0] s2;
  word_t                 a2 [4];
  logic [1:0]            cmd2;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      e1[i] = sum_t'(p1[i]);
    end
    sw = e1[0] - e1[1] - e1[2] - e1[3] + HALF_S;
    sx = e1[4] + e1[5] + e1[6] - e1[7] + HALF_S;
    sy = e1[8] + e1[9] - e1[10] + e1[11] + HALF_S;
    sz = e1[12] + e1[13] + e1[14] - e1[15] + HALF_S;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2[0] <= sw[SUM_BITS-1:FRAC_BITS];
      r2[1] <= sx[SUM_BITS-1:FRAC_BITS];
      r2[2] <= sy[SUM_BITS-1:FRAC_BITS];
      r2[3] <= sz[SUM_BITS-1:FRAC_BITS];
      s2    <= $unsigned(p1[16]) + $unsigned(p1[17]) + $unsigned(p1[18]) + ONE2F_SQ;
      a2    <= a1;
      cmd2  <= cmd1;
    end
  end

  // stage 3: product sign fix and saturation, divide operands
  side_t                 side3_next;
  side_t                 side3;
  logic [SQ_IN_BITS-1:0] s3;
  sat_t                  pv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pv[i] = r2[0][RND_BITS-1] ? -sat_t'(r2[i]) : sat_t'(r2[i]);
    end
    side3_next.cmd   = cmd2;
    side3_next.ax    = a2[1];
    side3_next.ay    = a2[2];
    side3_next.az    = a2[3];
    side3_next.qw    = sat_word(pv[0]);
    side3_next.qx    = sat_word(pv[1]);
    side3_next.qy    = sat_word(pv[2]);
    side3_next.qz    = sat_word(pv[3]);
    side3_next.qsat  = sat_ovf(pv[0]) | sat_ovf(pv[1]) | sat_ovf(pv[2]) | sat_ovf(pv[3]);
    side3_next.ux    = abs_word(a2[1]);
    side3_next.uy    = abs_word(a2[2]);
    side3_next.uz    = abs_word(a2[3]);
    side3_next.ud    = abs_word(a2[0]);
    side3_next.neg   = {a2[3][WORD_BITS-1] ^ a2[0][WORD_BITS-1],
                        a2[2][WORD_BITS-1] ^ a2[0][WORD_BITS-1],
                        a2[1][WORD_BITS-1] ^ a2[0][WORD_BITS-1]};
    side3_next.azero = (a2[0] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3 <= side3_next;
      s3    <= s2;
    end
  end

  // square root of the norm, side data delayed alongside
  logic [SQ_STAGES-1:0] q35;
  side_t                d1 [SQ_STAGES];

  oqu_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .n    (s3),
    .root (q35)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= side3;
      for (int k = 1; k < SQ_STAGES; k++) begin
        d1[k] <= d1[k-1];
      end
    end
  end

  // divider operands: lane x divides one by the root for a rodrigues-to-quaternion request
  side_t               sd;
  logic [NUM_BITS-1:0] nx, ny, nz;
  logic [DEN_BITS-1:0] dx_den;
  logic [NUM_BITS-1:0] half_d;

  always_comb begin
    sd     = d1[SQ_STAGES-1];
    half_d = NUM_BITS'(sd.ud >> 1);
    ny     = {sd.uy, {FRAC_BITS{1'b0}}} + half_d;
    nz     = {sd.uz, {FRAC_BITS{1'b0}}} + half_d;
    if (sd.cmd == CMD_TO_QUAT) begin
      nx     = ONE2F + NUM_BITS'(q35 >> 1);
      dx_den = DEN_BITS'(q35);
    end else begin
      nx     = {sd.ux, {FRAC_BITS{1'b0}}} + half_d;
      dx_den = sd.ud;
    end
  end

  logic [NUM_BITS-1:0] qx91, qy91, qz91;
  side_t               d2 [DV_STAGES];

  oqu_div u_div_x (.clk(clk), .en(adv), .num(nx), .den(dx_den), .quo(qx91));
  oqu_div u_div_y (.clk(clk), .en(adv), .num(ny), .den(sd.ud), .quo(qy91));
  oqu_div u_div_z (.clk(clk), .en(adv), .num(nz), .den(sd.ud), .quo(qz91));

  always_ff @(posedge clk) begin
    if (adv) begin
      d2[0] <= sd;
      for (int k = 1; k < DV_STAGES; k++) begin
        d2[k] <= d2[k-1];
      end
    end
  end

  // stage 92: scale the vector by c, sign and saturate the quotients
  side_t se;
  side_t e92;
  word_t c92;
  mul_t  m92 [3];
  word_t dq92 [3];
  logic  dsat92;
  sat_t  dv [3];
  mul_t  cm;

  always_comb begin
    se    = d2[DV_STAGES-1];
    cm    = MUL_BITS'($signed({1'b0, qx91[FRAC_BITS:0]}));
    dv[0] = se.neg[0] ? -sat_t'($signed({1'b0, qx91})) : sat_t'($signed({1'b0, qx91}));
    dv[1] = se.neg[1] ? -sat_t'($signed({1'b0, qy91})) : sat_t'($signed({1'b0, qy91}));
    dv[2] = se.neg[2] ? -sat_t'($signed({1'b0, qz91})) : sat_t'($signed({1'b0, qz91}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e92    <= se;
      c92    <= qx91[WORD_BITS-1:0];
      m92[0] <= cm * MUL_BITS'(se.ax);
      m92[1] <= cm * MUL_BITS'(se.ay);
      m92[2] <= cm * MUL_BITS'(se.az);
      for (int i = 0; i < 3; i++) begin
        dq92[i] <= sat_word(dv[i]);
      end
      dsat92 <= sat_ovf(dv[0]) | sat_ovf(dv[1]) | sat_ovf(dv[2]);
    end
  end

  // stage 93: round the scaled vector, select the result by command
  mul_t       mr [3];
  word_t      o_next [4];
  logic [1:0] f_next;
  word_t      o_r [4];
  logic [1:0] f_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mr[i] = m92[i] + HALF_M;
    end
    case (e92.cmd)
      CMD_TO_QUAT: begin
        o_next[0] = c92;
        o_next[1] = mr[0][FRAC_BITS+WORD_BITS-1:FRAC_BITS];
        o_next[2] = mr[1][FRAC_BITS+WORD_BITS-1:FRAC_BITS];
        o_next[3] = mr[2][FRAC_BITS+WORD_BITS-1:FRAC_BITS];
        f_next    = FAULT_OK;
      end
      CMD_PRODUCT: begin
        o_next[0] = e92.qw;
        o_next[1] = e92.qx;
        o_next[2] = e92.qy;
        o_next[3] = e92.qz;
        f_next    = e92.qsat ? FAULT_SAT : FAULT_OK;
      end
      CMD_TO_ROD: begin
        o_next[0] = '0;
        if (e92.azero) begin
          o_next[1] = '0;
          o_next[2] = '0;
          o_next[3] = '0;
          f_next    = FAULT_DIV0;
        end else begin
          o_next[1] = dq92[0];
          o_next[2] = dq92[1];
          o_next[3] = dq92[2];
          f_next    = dsat92 ? FAULT_SAT : FAULT_OK;
        end
      end
      default: begin
        o_next[0] = '0;
        o_next[1] = '0;
        o_next[2] = '0;
        o_next[3] = '0;
        f_next    = FAULT_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r <= o_next;
      f_r <= f_next;
    end
  end

  assign m_tdata = {o_r[3], o_r[2], o_r[1], o_r[0]};
  assign m_tuser = f_r;

endmodule
